### sv/svf_pkg.sv
// Shared constants, types and saturation helpers for the state-variable filter.
`timescale 1ns / 1ps
`default_nettype none

package svf_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int GUARD_BITS     = 8;
    localparam int COEF_FRAC_BITS = 18;

    localparam int STATE_BITS = SAMPLE_BITS + GUARD_BITS;
    localparam int FREQ_BITS  = COEF_FRAC_BITS + 1;
    localparam int DAMP_BITS  = COEF_FRAC_BITS + 2;

    // coefficient (zero-extended, plus sign) times state
    localparam int PROD_BITS  = DAMP_BITS + 1 + STATE_BITS;
    localparam int MUL_BITS   = PROD_BITS - COEF_FRAC_BITS;
    // two guard bits cover a three-term sum of state, product and sample
    localparam int SUM_BITS   = MUL_BITS + 2;
    localparam int NOTCH_BITS = STATE_BITS + 1;

    // APB register map
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;
    localparam logic REG_FREQ = 1'b0;
    localparam logic REG_DAMP = 1'b1;

    localparam logic [FREQ_BITS-1:0] FREQ_RESET = FREQ_BITS'(26214);
    localparam logic [DAMP_BITS-1:0] DAMP_RESET = DAMP_BITS'(262144);

    // datapath commands issued by the sequencer
    typedef struct packed {
        logic x_load;     // capture the incoming sample
        logic mul_en;     // register the shared multiplier product
        logic coef_damp;  // multiplier coefficient: 0 freq, 1 damping
        logic val_high;   // multiplier operand: 0 band state, 1 highpass
        logic low_load;   // update low state
        logic high_load;  // capture highpass node
        logic out_load;   // update band state and load result register
    } t_cmd;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] lowpass_out;
        logic signed [SAMPLE_BITS-1:0] highpass_out;
        logic signed [SAMPLE_BITS-1:0] bandpass_out;
        logic signed [SAMPLE_BITS-1:0] notch_out;
    } t_result;

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [SUM_BITS-1:0] v
    );
        logic [SUM_BITS-STATE_BITS:0] upper;
        logic signed [STATE_BITS-1:0] res;
        upper = v[SUM_BITS-1:STATE_BITS-1];
        priority if (&upper || ~|upper) begin
            res = v[STATE_BITS-1:0];
        end else if (v[SUM_BITS-1]) begin
            res = {1'b1, {(STATE_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(STATE_BITS-1){1'b1}}};
        end
        return res;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [NOTCH_BITS-1:0] v
    );
        logic [NOTCH_BITS-SAMPLE_BITS:0] upper;
        logic signed [SAMPLE_BITS-1:0] res;
        upper = v[NOTCH_BITS-1:SAMPLE_BITS-1];
        priority if (&upper || ~|upper) begin
            res = v[SAMPLE_BITS-1:0];
        end else if (v[NOTCH_BITS-1]) begin
            res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### sv/svf_if.sv
// Valid/ready item channels for samples in and filter results out.
`timescale 1ns / 1ps
`default_nettype none

interface svf_in_if import svf_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface svf_out_if import svf_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] lowpass_out;
    logic signed [SAMPLE_BITS-1:0] highpass_out;
    logic signed [SAMPLE_BITS-1:0] bandpass_out;
    logic signed [SAMPLE_BITS-1:0] notch_out;

    modport source (output valid, output lowpass_out, output highpass_out,
                    output bandpass_out, output notch_out, input ready);
    modport sink   (input valid, input lowpass_out, input highpass_out,
                    input bandpass_out, input notch_out, output ready);
endinterface

`default_nettype wire

### sv/state_variable_filter.sv
// Top level of the fixed-point Chamberlin state-variable filter.
//
// Usage:
//   i_in  : sample items, signed Q1.23 (sample_in). One item gives one result.
//   o_out : result items with lowpass, highpass, bandpass and notch, each
//           signed Q1.23 and saturated to 24 bits.
//   APB   : freq_coef at byte 0x0 (19 bits), damping_coef at 0x4 (20 bits),
//           both unsigned with 18 fraction bits. Write only while idle.
// Timing:
//   A sample is accepted in the idle cycle; the step then runs S_MUL_DAMP,
//   S_HIGH, S_MUL_FREQ and S_BAND, and o_out.valid rises when S_BAND loads the
//   output register. One shared multiplier runs freq*band, damping*band and
//   freq*high in turn, so a new sample is taken only once the step is through.
//   The output register frees the pipe: a new sample is taken while a result
//   waits. If the receiver still holds the previous result when the next one
//   is done, the sequencer waits in its last step and i_in.ready stays low.
// Reset (synchronous, active low):
//   Band and low states clear to zero, coefficients return to freq 26214
//   (about 0.1) and damping 262144 (1.0), and no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module state_variable_filter import svf_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    svf_in_if.sink                        i_in,
    svf_out_if.source                     o_out,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    logic [FREQ_BITS-1:0] r_freq_coef;
    logic [DAMP_BITS-1:0] r_damping_coef;
    logic                 reg_sel;
    logic                 cfg_wr;
    t_cmd                 cmd;
    t_result              result;

    // --- configuration registers ---
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_coef    <= FREQ_RESET;
            r_damping_coef <= DAMP_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_FREQ: r_freq_coef    <= pwdata[FREQ_BITS-1:0];
                REG_DAMP: r_damping_coef <= pwdata[DAMP_BITS-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_FREQ: prdata = APB_DATA_BITS'(r_freq_coef);
            REG_DAMP: prdata = APB_DATA_BITS'(r_damping_coef);
            default:  prdata = '0;
        endcase
    end

    // --- sequencer ---
    svf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // --- arithmetic and state ---
    svf_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_freq_coef    (r_freq_coef),
        .i_damping_coef (r_damping_coef),
        .i_sample_in    (i_in.sample_in),
        .o_result       (result)
    );

    assign o_out.lowpass_out  = result.lowpass_out;
    assign o_out.highpass_out = result.highpass_out;
    assign o_out.bandpass_out = result.bandpass_out;
    assign o_out.notch_out    = result.notch_out;

endmodule

`default_nettype wire

### sv/svf_ctrl.sv
// Sequencer for one filter step: drives the shared multiplier and result handshake.
`timescale 1ns / 1ps
`default_nettype none

module svf_ctrl import svf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire logic i_out_ready,
    output logic      o_out_valid,
    output t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MUL_DAMP = 3'd1;
    localparam logic [2:0] S_HIGH     = 3'd2;
    localparam logic [2:0] S_MUL_FREQ = 3'd3;
    localparam logic [2:0] S_BAND     = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // freq * band only needs state, so it runs in the accept cycle
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.x_load = 1'b1;
                    o_cmd.mul_en = 1'b1;
                    n_state      = S_MUL_DAMP;
                end
            end
            S_MUL_DAMP: begin
                o_cmd.low_load  = 1'b1;
                o_cmd.mul_en    = 1'b1;
                o_cmd.coef_damp = 1'b1;
                n_state         = S_HIGH;
            end
            S_HIGH: begin
                o_cmd.high_load = 1'b1;
                n_state         = S_MUL_FREQ;
            end
            S_MUL_FREQ: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.val_high = 1'b1;
                n_state        = S_BAND;
            end
            S_BAND: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### sv/svf_datapath.sv
// Filter datapath: shared coefficient multiplier, integrator states, result register.
`timescale 1ns / 1ps
`default_nettype none

module svf_datapath import svf_pkg::*; (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_cmd                          i_cmd,
    input  wire logic [FREQ_BITS-1:0]          i_freq_coef,
    input  wire logic [DAMP_BITS-1:0]          i_damping_coef,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output t_result                            o_result
);

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [MUL_BITS-1:0]    r_prod;
    logic signed [STATE_BITS-1:0]  r_low;
    logic signed [STATE_BITS-1:0]  r_band;
    logic signed [STATE_BITS-1:0]  r_high;
    t_result                       r_result, n_result;

    logic signed [DAMP_BITS:0]     mul_a;
    logic signed [STATE_BITS-1:0]  mul_b;
    logic signed [PROD_BITS-1:0]   mul_p;
    logic signed [STATE_BITS-1:0]  low_n, high_n, band_n;
    logic signed [NOTCH_BITS-1:0]  notch_sum;

    // single multiplier; the arithmetic shift floors toward minus infinity
    assign mul_a = i_cmd.coef_damp ? $signed({1'b0, i_damping_coef})
                                   : $signed({2'b00, i_freq_coef});
    assign mul_b = i_cmd.val_high ? r_high : r_band;
    assign mul_p = mul_a * mul_b;

    assign low_n  = sat_state(SUM_BITS'(r_low) + SUM_BITS'(r_prod));
    assign high_n = sat_state(SUM_BITS'(r_x) - SUM_BITS'(r_low) - SUM_BITS'(r_prod));
    assign band_n = sat_state(SUM_BITS'(r_prod) + SUM_BITS'(r_band));
    assign notch_sum = NOTCH_BITS'(r_high) + NOTCH_BITS'(r_low);

    always_comb begin
        n_result.lowpass_out  = sat_sample(NOTCH_BITS'(r_low));
        n_result.highpass_out = sat_sample(NOTCH_BITS'(r_high));
        n_result.bandpass_out = sat_sample(NOTCH_BITS'(band_n));
        n_result.notch_out    = sat_sample(notch_sum);
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_band <= '0;
        end else begin
            if (i_cmd.low_load) begin
                r_low <= low_n;
            end
            if (i_cmd.out_load) begin
                r_band <= band_n;
            end
        end
    end

    // working registers and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.x_load) begin
            r_x <= i_sample_in;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p[PROD_BITS-1:COEF_FRAC_BITS];
        end
        if (i_cmd.high_load) begin
            r_high <= high_n;
        end
        if (i_cmd.out_load) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

### sv/svf_checker.sv
// Port-level checks for the state-variable filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module svf_checker import svf_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   i_in_ready,
    input wire logic                   i_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [SAMPLE_BITS-1:0] i_out_low
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // no result may be pending right after a reset cycle
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

    // one item at a time: input closed through S_MUL_DAMP, S_HIGH, S_MUL_FREQ and S_BAND
    a_busy_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready ##1 !i_in_ready ##1 !i_in_ready ##1 !i_in_ready)
        else $error("input accepted while a step is in progress");

    // a fresh result appears only after a sample was taken and the working states have run
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_acc, 5))
        else $error("result without matching sample");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_low))
        else $error("result changed while stalled");

endmodule

bind state_variable_filter svf_checker u_svf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_low   (o_out.lowpass_out)
);

`default_nettype wire

### bench/state_variable_filter_tb.sv
// Self-checking bench for the state-variable filter: directed table, then random runs.
`timescale 1ns / 1ps

module state_variable_filter_tb;
    import svf_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 20;

    localparam logic [APB_ADDR_BITS-1:0] ADDR_FREQ = APB_ADDR_BITS'({REG_FREQ, 2'b00});
    localparam logic [APB_ADDR_BITS-1:0] ADDR_DAMP = APB_ADDR_BITS'({REG_DAMP, 2'b00});

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX  = 24'h7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN  = 24'h800000;
    localparam logic signed [SAMPLE_BITS-1:0] S_ZERO = 24'h000000;

    // directed table rows: a sample item or a coefficient write
    typedef enum logic [1:0] {ROW_SAMPLE, ROW_WR_FREQ, ROW_WR_DAMP} t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [APB_DATA_BITS-1:0]      wdata;
        logic                          typed;   // res below is the expectation
        t_result                       res;
    } t_stim_row;

    localparam t_result NO_RES   = '0;
    // first full-scale step from cleared state: low 0, high = x, band = f*x
    localparam t_result RES_STEP = '{S_ZERO, S_MAX, 24'sd838847, S_MAX};

    localparam int N_DIR = 25;
    localparam t_stim_row DIR_TAB [N_DIR] = '{
        '{ROW_SAMPLE,  S_ZERO,         32'h0,         1'b1, NO_RES},
        '{ROW_SAMPLE,  S_MAX,          32'h0,         1'b1, RES_STEP},
        '{ROW_SAMPLE,  S_MIN,          32'h0,         1'b0, NO_RES},
        '{ROW_SAMPLE,  24'sd1,         32'h0,         1'b0, NO_RES},
        '{ROW_SAMPLE,  -24'sd1,        32'h0,         1'b0, NO_RES},
        '{ROW_SAMPLE,  S_MAX,          32'h0,         1'b0, NO_RES},
        // zero coefficients: integrators frozen
        '{ROW_WR_FREQ, S_ZERO,         32'h0,         1'b0, NO_RES},
        '{ROW_WR_DAMP, S_ZERO,         32'h0,         1'b0, NO_RES},
        '{ROW_SAMPLE,  24'sd4194304,   32'h0,         1'b0, NO_RES},
        '{ROW_SAMPLE,  S_MIN,          32'h0,         1'b0, NO_RES},
        // all-ones writes: above-range coefficients, upper bits dropped
        '{ROW_WR_FREQ, S_ZERO,         32'hFFFF_FFFF, 1'b0, NO_RES},
        '{ROW_WR_DAMP, S_ZERO,         32'hFFFF_FFFF, 1'b0, NO_RES},
        '{ROW_SAMPLE,  S_MAX,          32'h0,         1'b0, NO_RES},
        '{ROW_SAMPLE,  S_MAX,          32'h0,         1'b0, NO_RES},
        '{ROW_SAMPLE,  S_MIN,          32'h0,         1'b0, NO_RES},
        '{ROW_SAMPLE,  S_MIN,          32'h0,         1'b0, NO_RES},
        '{ROW_SAMPLE,  S_MAX,          32'h0,         1'b0, NO_RES},
        // top of the documented ranges
        '{ROW_WR_FREQ, S_ZERO,         32'd262144,    1'b0, NO_RES},
        '{ROW_WR_DAMP, S_ZERO,         32'd524288,    1'b0, NO_RES},
        '{ROW_SAMPLE,  S_MIN,          32'h0,         1'b0, NO_RES},
        '{ROW_SAMPLE,  S_MAX,          32'h0,         1'b0, NO_RES},
        '{ROW_SAMPLE,  S_ZERO,         32'h0,         1'b0, NO_RES},
        // back to reset values, with junk above the freq field
        '{ROW_WR_FREQ, S_ZERO,         32'hFFF8_6666, 1'b0, NO_RES},
        '{ROW_WR_DAMP, S_ZERO,         32'd262144,    1'b0, NO_RES},
        '{ROW_SAMPLE,  24'sd123456,    32'h0,         1'b0, NO_RES}
    };

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    svf_in_if  in_if ();
    svf_out_if out_if ();

    state_variable_filter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the integrators and coefficients
    logic signed [STATE_BITS-1:0] band_st;
    logic signed [STATE_BITS-1:0] low_st;
    logic [FREQ_BITS-1:0]         freq_reg;
    logic [DAMP_BITS-1:0]         damp_reg;

    t_result resp_q [$];      // predicted filter responses, oldest first

    // typed expectation travels with the item, driven alongside valid
    logic    cur_typed;
    t_result cur_res;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_token;
    int err_cnt;
    int n_in;
    int n_out;
    int n_wr;
    int cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // floor(c * v / 2^COEF_FRAC_BITS); product fits easily in 64 bits
    function automatic longint coef_scale(input logic [DAMP_BITS-1:0] c, input longint v);
        longint prod;
        prod = longint'(c) * v;
        return prod >>> COEF_FRAC_BITS;
    endfunction

    function automatic longint clamp_to(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // one filter step: low, high, band in dependency order, states saturate
    function automatic t_result filter_update(input logic signed [SAMPLE_BITS-1:0] x);
        longint  lp;
        longint  hp;
        longint  bp;
        t_result r;
        lp = clamp_to(longint'(low_st) + coef_scale(freq_reg, longint'(band_st)),
                      STATE_BITS);
        hp = clamp_to(longint'(x) - lp - coef_scale(damp_reg, longint'(band_st)),
                      STATE_BITS);
        bp = clamp_to(coef_scale(freq_reg, hp) + longint'(band_st), STATE_BITS);
        band_st = STATE_BITS'(bp);
        low_st  = STATE_BITS'(lp);
        r.lowpass_out  = SAMPLE_BITS'(clamp_to(lp, SAMPLE_BITS));
        r.highpass_out = SAMPLE_BITS'(clamp_to(hp, SAMPLE_BITS));
        r.bandpass_out = SAMPLE_BITS'(clamp_to(bp, SAMPLE_BITS));
        r.notch_out    = SAMPLE_BITS'(clamp_to(hp + lp, SAMPLE_BITS));
        return r;
    endfunction

    // input side: predict at every accepted sample
    initial begin
        t_result pred;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && in_if.valid && in_if.ready) begin
                pred = filter_update(in_if.sample_in);
                resp_q.push_back(cur_typed ? cur_res : pred);
                n_in++;
            end
        end
    end

    // output side: check accepted results, then pick ready for the next cycle
    initial begin
        t_result want;
        int      hold_seen;
        int      hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                n_out++;
                if (resp_q.size() == 0) begin
                    $error("result with no expectation: lp %0d hp %0d bp %0d n %0d",
                           out_if.lowpass_out, out_if.highpass_out,
                           out_if.bandpass_out, out_if.notch_out);
                    err_cnt++;
                end else begin
                    want = resp_q.pop_front();
                    if (out_if.lowpass_out !== want.lowpass_out) begin
                        $error("lowpass_out: expected %0d, got %0d",
                               want.lowpass_out, out_if.lowpass_out);
                        err_cnt++;
                    end
                    if (out_if.highpass_out !== want.highpass_out) begin
                        $error("highpass_out: expected %0d, got %0d",
                               want.highpass_out, out_if.highpass_out);
                        err_cnt++;
                    end
                    if (out_if.bandpass_out !== want.bandpass_out) begin
                        $error("bandpass_out: expected %0d, got %0d",
                               want.bandpass_out, out_if.bandpass_out);
                        err_cnt++;
                    end
                    if (out_if.notch_out !== want.notch_out) begin
                        $error("notch_out: expected %0d, got %0d",
                               want.notch_out, out_if.notch_out);
                        err_cnt++;
                    end
                end
            end
            // a new token starts a long hold-off so the pipe backs up
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // offer one sample; valid stays up afterwards unless the next item idles first
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x,
                               input logic typed, input t_result res);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.sample_in <= x;
        cur_typed       <= typed;
        cur_res         <= res;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // stop offering and wait until every predicted response has come back
    task automatic drain_pipe();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (resp_q.size() != 0) @(posedge i_clk);
    endtask

    // setup and access phases, then idle before the next transfer
    task automatic apb_cycle(input logic wr, input logic [APB_ADDR_BITS-1:0] addr,
                             input logic [APB_DATA_BITS-1:0] wdata,
                             output logic [APB_DATA_BITS-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_readback(input logic [APB_ADDR_BITS-1:0] addr,
                                  input logic [APB_DATA_BITS-1:0] want);
        logic [APB_DATA_BITS-1:0] rd;
        apb_cycle(1'b0, addr, '0, rd);
        if (rd !== want) begin
            $error("prdata@%0h: expected %0d, got %0d", addr, want, rd);
            err_cnt++;
        end
    endtask

    // only called with the pipe drained
    task automatic write_coef(input logic [APB_ADDR_BITS-1:0] addr,
                              input logic [APB_DATA_BITS-1:0] data);
        logic [APB_DATA_BITS-1:0] dummy;
        apb_cycle(1'b1, addr, data, dummy);
        n_wr++;
        if (addr == ADDR_FREQ) begin
            freq_reg = data[FREQ_BITS-1:0];
            check_readback(addr, APB_DATA_BITS'(freq_reg));
        end else begin
            damp_reg = data[DAMP_BITS-1:0];
            check_readback(addr, APB_DATA_BITS'(damp_reg));
        end
    endtask

    initial begin
        t_stim_row                     row;
        logic signed [SAMPLE_BITS-1:0] s;
        logic signed [SAMPLE_BITS-1:0] level;
        logic signed [SAMPLE_BITS-1:0] step;
        logic [APB_DATA_BITS-1:0]      junk;
        logic [FREQ_BITS-1:0]          fsel;
        logic [DAMP_BITS-1:0]          dsel;
        int                            sent;
        int                            run_len;
        int                            run_kind;

        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_if.valid     = 1'b0;
        in_if.sample_in = '0;
        cur_typed       = 1'b0;
        cur_res         = '0;
        band_st         = '0;
        low_st          = '0;
        freq_reg        = FREQ_RESET;
        damp_reg        = DAMP_RESET;
        send_idle_pct   = 7;
        recv_idle_pct   = 51;
        hold_token      = 0;
        err_cnt         = 0;
        n_in            = 0;
        n_out           = 0;
        n_wr            = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // coefficients out of reset
        check_readback(ADDR_FREQ, APB_DATA_BITS'(FREQ_RESET));
        check_readback(ADDR_DAMP, APB_DATA_BITS'(DAMP_RESET));

        // directed table
        for (int i = 0; i < N_DIR; i++) begin
            row = DIR_TAB[i];
            case (row.kind)
                ROW_SAMPLE: begin
                    send_sample(row.sample, row.typed, row.res);
                end
                ROW_WR_FREQ: begin
                    drain_pipe();
                    write_coef(ADDR_FREQ, row.wdata);
                end
                default: begin
                    drain_pipe();
                    write_coef(ADDR_DAMP, row.wdata);
                end
            endcase
        end

        // random phases, each under its own coefficient pair and one of three idle mixes
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_pipe();
            if (ph < 3) begin
                send_idle_pct <= 7;
                recv_idle_pct <= 51;
            end else if (ph < 6) begin
                send_idle_pct <= 51;
                recv_idle_pct <= 7;
            end else begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            case (ph)
                0: begin
                    fsel = FREQ_BITS'($urandom_range(1000, 60000));
                    dsel = DAMP_BITS'($urandom_range(100000, 524288));
                end
                1: begin
                    fsel = FREQ_BITS'(262144);
                    dsel = DAMP_BITS'(524288);
                end
                2: begin
                    fsel = '0;
                    dsel = '0;
                end
                3: begin
                    fsel = '1;
                    dsel = '1;
                end
                5: begin
                    // low damping: resonant, drives the states into saturation
                    fsel = FREQ_BITS'($urandom_range(1, 8000));
                    dsel = '0;
                end
                7: begin
                    fsel = FREQ_BITS'(262144);
                    dsel = DAMP_BITS'(1);
                end
                default: begin
                    fsel = FREQ_BITS'($urandom());
                    dsel = DAMP_BITS'($urandom());
                end
            endcase
            // junk in the unused upper bits must be dropped
            junk = $urandom();
            write_coef(ADDR_FREQ, {junk[APB_DATA_BITS-1:FREQ_BITS], fsel});
            junk = $urandom();
            write_coef(ADDR_DAMP, {junk[APB_DATA_BITS-1:DAMP_BITS], dsel});
            if (ph == 6) hold_token <= hold_token + 1;

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                run_len  = $urandom_range(1, 24);
                run_kind = $urandom_range(0, 9);
                level    = SAMPLE_BITS'($urandom());
                step     = SAMPLE_BITS'($urandom_range(0, 131071)) - 24'sd65536;
                for (int k = 0; k < run_len; k++) begin
                    case (run_kind)
                        4, 5:    s = SAMPLE_BITS'($urandom_range(0, 511)) - 24'sd256;
                        6:       s = k[0] ? S_MIN : S_MAX;
                        7:       s = level;
                        8:       s = level[SAMPLE_BITS-1] ? S_MIN : S_MAX;
                        9:       s = level + SAMPLE_BITS'(k) * step;
                        default: s = SAMPLE_BITS'($urandom());
                    endcase
                    send_sample(s, 1'b0, NO_RES);
                    sent++;
                end
            end
        end

        drain_pipe();
        repeat (SETTLE) @(posedge i_clk);
        if (resp_q.size() != 0) begin
            $error("%0d expected results never arrived", resp_q.size());
            err_cnt++;
        end

        $display("Ran %0d samples, checked %0d results over %0d coefficient writes,",
                 n_in, n_out, n_wr);
        $display("covering zero, full-scale and above-range coefficients and a %0d-cycle stall.",
                 HOLD_CYCLES);
        if (err_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
